// File: sv/alstep_pkg.sv
// Shared types and constants for the antialiased line stepper.
`timescale 1ns / 1ps

package alstep_pkg;

    // Clip registers are fixed 12-bit two's complement values.
    localparam int CLIP_BITS     = 12;
    localparam int FRAC_BITS     = 16;  // width of the error step and accumulator fraction
    localparam int STEP_CNT_BITS = 13;  // remaining-step counter

    localparam logic signed [CLIP_BITS-1:0] CLIP_LEFT_RST   = 12'sd0;
    localparam logic signed [CLIP_BITS-1:0] CLIP_RIGHT_RST  = 12'sd2047;
    localparam logic signed [CLIP_BITS-1:0] CLIP_TOP_RST    = 12'sd0;
    localparam logic signed [CLIP_BITS-1:0] CLIP_BOTTOM_RST = 12'sd2047;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_PAIR      = 2'd0,
        STAT_REJECT    = 2'd1,
        STAT_SPAN      = 2'd2,
        STAT_IDLE_STEP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_RIGHT  = 2'd1,
        REG_CLIP_TOP    = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } cfg_reg_t;

    // What the front decided about a queued word.
    typedef enum logic [1:0] {
        KIND_STEP   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_DRAW   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
    } entry_ctl_t;

    typedef struct packed {
        logic [CLIP_BITS-1:0] left;
        logic [CLIP_BITS-1:0] right;
        logic [CLIP_BITS-1:0] top;
        logic [CLIP_BITS-1:0] bottom;
    } clip_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLASS,
        ST_DIV,
        ST_FIRST,
        ST_SPAN
    } back_state_t;

endpackage

// File: sv/alstep_front.sv
// Front end: endpoint ordering by x, clip rejection and x clamping.
`timescale 1ns / 1ps

module alstep_front #(
    parameter int COORD_BITS = 12,
    parameter int VB         = 12
) (
    input  logic                          cmd,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  alstep_pkg::clip_t             clip,
    output alstep_pkg::entry_ctl_t        ctl,
    output logic signed [VB-1:0]          x1,
    output logic signed [VB-1:0]          y1,
    output logic signed [VB-1:0]          x2,
    output logic signed [VB-1:0]          y2
);

    logic signed [VB-1:0] ax, ay, bx, by;
    logic signed [VB-1:0] lx, ly, rx, ry;
    logic signed [VB-1:0] c_left, c_right, c_top, c_bottom;
    logic                 swap, reject;

    always_comb begin
        ax = VB'(start_x);
        ay = VB'(start_y);
        bx = VB'(end_x);
        by = VB'(end_y);
        c_left   = VB'($signed(clip.left));
        c_right  = VB'($signed(clip.right));
        c_top    = VB'($signed(clip.top));
        c_bottom = VB'($signed(clip.bottom));

        // left endpoint first, y travels with its x
        swap = bx < ax;
        lx = swap ? bx : ax;
        ly = swap ? by : ay;
        rx = swap ? ax : bx;
        ry = swap ? ay : by;

        reject = (ax == bx) || (ly < c_top) || (ly >= c_bottom);

        x1 = (lx < c_left) ? c_left : lx;
        y1 = ly;
        x2 = (rx >= c_right) ? c_right : rx;
        y2 = ry;

        if (alstep_pkg::cmd_t'(cmd) == alstep_pkg::CMD_STEP) begin
            ctl.kind = alstep_pkg::KIND_STEP;
        end else if (reject) begin
            ctl.kind = alstep_pkg::KIND_REJECT;
        end else begin
            ctl.kind = alstep_pkg::KIND_DRAW;
        end
    end

endmodule

// File: sv/alstep_fifo.sv
// Short flop-based queue between the front end and the stepping back end.
`timescale 1ns / 1ps

module alstep_fifo #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

// File: sv/alstep_div.sv
// Restoring divider: 16 fraction bits of minor/major, one bit per cycle.
`timescale 1ns / 1ps

module alstep_div #(
    parameter int VB = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [VB-1:0]                       minor,
    input  logic [VB-1:0]                       major,
    output alstep_pkg::div_status_t             st,
    output logic [alstep_pkg::FRAC_BITS-1:0]    quotient
);

    localparam int FB    = alstep_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(FB + 1);

    logic [VB-1:0]    major_reg, rem_reg, rem_next;
    logic [FB-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [VB:0]      rem2, diff;
    logic             ge;

    always_comb begin
        rem2     = {rem_reg, 1'b0};
        diff     = rem2 - {1'b0, major_reg};
        ge       = rem2 >= {1'b0, major_reg};
        rem_next = ge ? diff[VB-1:0] : rem2[VB-1:0];
    end

    assign st.busy  = run_reg;
    assign st.done  = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(FB);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // minor == major would set the integer bit, which is dropped; remainder is zero
    always_ff @(posedge aclk) begin
        if (start) begin
            major_reg <= major;
            rem_reg   <= (minor == major) ? '0 : minor;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FB-2:0], ge};
        end
    end

`ifndef SYNTHESIS
    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg))
        else $error("divider done without a running division");
`endif

endmodule

// File: sv/alstep_back.sv
// Back end: line setup, fraction division control, pixel-pair stepping, output register.
`timescale 1ns / 1ps

module alstep_back #(
    parameter int COORD_BITS  = 12,
    parameter int WEIGHT_BITS = 8,
    parameter int VB          = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  alstep_pkg::entry_ctl_t        q_ctl,
    input  logic signed [VB-1:0]          q_x1,
    input  logic signed [VB-1:0]          q_y1,
    input  logic signed [VB-1:0]          q_x2,
    input  logic signed [VB-1:0]          q_y2,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output alstep_pkg::status_t           out_status,
    output logic [COORD_BITS-1:0]         out_main_x,
    output logic [COORD_BITS-1:0]         out_main_y,
    output logic [WEIGHT_BITS-1:0]        out_main_weight,
    output logic [COORD_BITS-1:0]         out_pair_x,
    output logic [COORD_BITS-1:0]         out_pair_y,
    output logic [WEIGHT_BITS-1:0]        out_pair_weight,
    output logic                          out_last
);

    localparam int CB = COORD_BITS;
    localparam int WB = WEIGHT_BITS;
    localparam int FB = alstep_pkg::FRAC_BITS;
    localparam int SB = alstep_pkg::STEP_CNT_BITS;

    alstep_pkg::back_state_t state_reg, state_next;
    alstep_pkg::div_status_t div_st;

    // control
    logic out_free, out_load, div_start;
    logic active_reg, active_next;
    logic out_valid_reg, out_valid_next;

    // latched endpoints and setup results
    logic signed [VB-1:0] pt_x1_reg, pt_y1_reg, pt_x2_reg, pt_y2_reg;
    logic signed [VB-1:0] ox_reg, oy_reg;
    logic signed [VB:0]   dxr_reg, dyr_reg;
    logic                 swap_reg;
    logic                 span;

    // line state
    logic          neg_reg, neg_next, ym_reg, ym_next;
    logic [SB-1:0] steps_reg, steps_next;
    logic [FB-1:0] acc_reg, acc_next, estep_reg, estep_next;
    logic [CB-1:0] cx_reg, cx_next, cy_reg, cy_next, nb_reg, nb_next;
    logic [FB-1:0] quotient;

    // class stage
    logic [VB:0]   adx_w, ady_w;
    logic [VB-1:0] adx, ady, major, minor;
    logic          c_neg, c_ym;
    logic [CB-1:0] c_cx, c_cy, c_dir;

    // step datapath
    logic [FB:0]   acc_sum;
    logic          roll;
    logic [WB-1:0] wgt;
    logic [CB-1:0] dir, s_cx, s_cy, s_nb;
    logic [SB-1:0] s_steps;
    logic          s_active;

    // output register
    alstep_pkg::status_t o_status_reg, o_status_next;
    logic [CB-1:0] o_mx_reg, o_mx_next, o_my_reg, o_my_next;
    logic [CB-1:0] o_px_reg, o_px_next, o_py_reg, o_py_next;
    logic [WB-1:0] o_mw_reg, o_mw_next, o_pw_reg, o_pw_next;
    logic          o_last_reg, o_last_next;

    alstep_div #(.VB(VB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .minor    (minor),
        .major    (major),
        .st       (div_st),
        .quotient (quotient)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign span     = (pt_x1_reg == pt_x2_reg) || (pt_y1_reg == pt_y2_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            alstep_pkg::ST_IDLE: begin
                if (q_valid && out_free && q_ctl.kind == alstep_pkg::KIND_DRAW) begin
                    state_next = alstep_pkg::ST_SETUP;
                end
            end
            alstep_pkg::ST_SETUP: begin
                state_next = span ? alstep_pkg::ST_SPAN : alstep_pkg::ST_CLASS;
            end
            alstep_pkg::ST_CLASS: state_next = alstep_pkg::ST_DIV;
            alstep_pkg::ST_DIV: begin
                if (div_st.done) begin
                    state_next = alstep_pkg::ST_FIRST;
                end
            end
            alstep_pkg::ST_FIRST, alstep_pkg::ST_SPAN: begin
                if (out_free) begin
                    state_next = alstep_pkg::ST_IDLE;
                end
            end
            default: state_next = alstep_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            alstep_pkg::ST_IDLE: begin
                q_pop    = q_valid && out_free;
                out_load = q_valid && out_free && q_ctl.kind != alstep_pkg::KIND_DRAW;
            end
            alstep_pkg::ST_CLASS: div_start = 1'b1;
            alstep_pkg::ST_FIRST, alstep_pkg::ST_SPAN: out_load = out_free;
            default: ;
        endcase
    end

    // class stage: magnitudes, major axis, first neighbour
    always_comb begin
        adx_w = dxr_reg[VB] ? -dxr_reg : dxr_reg;
        ady_w = dyr_reg[VB] ? -dyr_reg : dyr_reg;
        adx   = adx_w[VB-1:0];
        ady   = ady_w[VB-1:0];
        // y-order swap flips the sign of dx
        c_neg = (dxr_reg != '0) && (dxr_reg[VB] ^ swap_reg);
        c_ym  = ady > adx;
        major = c_ym ? ady : adx;
        minor = c_ym ? adx : ady;
        c_cx  = ox_reg[CB-1:0];
        c_cy  = oy_reg[CB-1:0];
        c_dir = c_neg ? '1 : CB'(1);
    end

    // one step of the line
    always_comb begin
        acc_sum  = {1'b0, acc_reg} + {1'b0, estep_reg};
        roll     = acc_sum[FB] || (estep_reg == '0);
        wgt      = acc_sum[FB-1 -: WB];
        dir      = neg_reg ? '1 : CB'(1);
        s_steps  = steps_reg - 1'b1;
        s_active = s_steps != '0;
        if (ym_reg) begin
            s_cx = roll ? nb_reg : cx_reg;
            s_nb = roll ? nb_reg + dir : nb_reg;
            s_cy = cy_reg + 1'b1;
        end else begin
            s_cy = roll ? nb_reg : cy_reg;
            s_nb = roll ? nb_reg + 1'b1 : nb_reg;
            s_cx = cx_reg + dir;
        end
    end

    // register next values
    always_comb begin
        active_next    = active_reg;
        neg_next       = neg_reg;
        ym_next        = ym_reg;
        steps_next     = steps_reg;
        acc_next       = acc_reg;
        estep_next     = estep_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        nb_next        = nb_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_status_next  = alstep_pkg::STAT_PAIR;
        o_mx_next      = '0;
        o_my_next      = '0;
        o_mw_next      = '0;
        o_px_next      = '0;
        o_py_next      = '0;
        o_pw_next      = '0;
        o_last_next    = 1'b0;

        unique case (state_reg)
            alstep_pkg::ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_ctl.kind)
                        alstep_pkg::KIND_STEP: begin
                            if (active_reg) begin
                                acc_next    = acc_sum[FB-1:0];
                                cx_next     = s_cx;
                                cy_next     = s_cy;
                                nb_next     = s_nb;
                                steps_next  = s_steps;
                                active_next = s_active;
                                o_mx_next   = s_cx;
                                o_my_next   = s_cy;
                                o_mw_next   = ~wgt;
                                o_px_next   = ym_reg ? s_nb : s_cx;
                                o_py_next   = ym_reg ? s_cy : s_nb;
                                o_pw_next   = wgt;
                                o_last_next = !s_active;
                            end else begin
                                o_status_next = alstep_pkg::STAT_IDLE_STEP;
                            end
                        end
                        alstep_pkg::KIND_REJECT: begin
                            active_next   = 1'b0;
                            o_status_next = alstep_pkg::STAT_REJECT;
                        end
                        default: active_next = 1'b0;
                    endcase
                end
            end
            alstep_pkg::ST_CLASS: begin
                neg_next   = c_neg;
                ym_next    = c_ym;
                steps_next = SB'(major - 1'b1);
                acc_next   = '0;
                cx_next    = c_cx;
                cy_next    = c_cy;
                nb_next    = c_ym ? c_cx + c_dir : c_cy + 1'b1;
            end
            alstep_pkg::ST_DIV: begin
                if (div_st.done) begin
                    estep_next = quotient;
                end
            end
            alstep_pkg::ST_FIRST: begin
                if (out_free) begin
                    active_next = steps_reg != '0;
                end
                o_mx_next   = cx_reg;
                o_my_next   = cy_reg;
                o_mw_next   = '1;
                o_px_next   = cx_reg;
                o_py_next   = cy_reg;
                o_last_next = steps_reg == '0;
            end
            alstep_pkg::ST_SPAN: begin
                o_status_next = alstep_pkg::STAT_SPAN;
                o_mx_next     = pt_x1_reg[CB-1:0];
                o_my_next     = pt_y1_reg[CB-1:0];
                o_mw_next     = '1;
                o_px_next     = pt_x2_reg[CB-1:0];
                o_py_next     = pt_y2_reg[CB-1:0];
                o_pw_next     = '1;
                o_last_next   = 1'b1;
            end
            default: ;
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= alstep_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        ym_reg    <= ym_next;
        acc_reg   <= acc_next;
        estep_reg <= estep_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        nb_reg    <= nb_next;
        if (state_reg == alstep_pkg::ST_IDLE && q_pop) begin
            pt_x1_reg <= q_x1;
            pt_y1_reg <= q_y1;
            pt_x2_reg <= q_x2;
            pt_y2_reg <= q_y2;
        end
        if (state_reg == alstep_pkg::ST_SETUP) begin
            swap_reg <= pt_y1_reg > pt_y2_reg;
            dxr_reg  <= (VB+1)'(pt_x2_reg) - (VB+1)'(pt_x1_reg);
            dyr_reg  <= (VB+1)'(pt_y2_reg) - (VB+1)'(pt_y1_reg);
            ox_reg   <= (pt_y1_reg > pt_y2_reg) ? pt_x2_reg : pt_x1_reg;
            oy_reg   <= (pt_y1_reg > pt_y2_reg) ? pt_y2_reg : pt_y1_reg;
        end
        if (out_load) begin
            o_status_reg <= o_status_next;
            o_mx_reg     <= o_mx_next;
            o_my_reg     <= o_my_next;
            o_mw_reg     <= o_mw_next;
            o_px_reg     <= o_px_next;
            o_py_reg     <= o_py_next;
            o_pw_reg     <= o_pw_next;
            o_last_reg   <= o_last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = o_status_reg;
    assign out_main_x      = o_mx_reg;
    assign out_main_y      = o_my_reg;
    assign out_main_weight = o_mw_reg;
    assign out_pair_x      = o_px_reg;
    assign out_pair_y      = o_py_reg;
    assign out_pair_weight = o_pw_reg;
    assign out_last        = o_last_reg;

`ifndef SYNTHESIS
    a_inactive_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != alstep_pkg::ST_IDLE) |-> !active_reg)
        else $error("line active while a new line is being set up");
    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == alstep_pkg::ST_DIV) |-> (div_st.busy || div_st.done))
        else $error("waiting on a divider that is not running");
`endif

endmodule

// File: sv/antialiased_line_stepper_core.sv
// Top level of the antialiased line stepper: clip registers, front end, queue, back end.
// A step word passes the queue and then the output register on its way to m_tvalid; steps then
// run one per cycle while words arrive and m_tready is high. A reject goes the same way; a span
// adds SETUP, SPAN; a first pixel SETUP, CLASS, DIV (one quotient bit per cycle), FIRST.
// The front keeps taking words into a 2-entry queue while the back end divides.
// Reset (aresetn low, synchronous): no line active, queue and output empty, clips to defaults.
`timescale 1ns / 1ps

module antialiased_line_stepper_core #(
    parameter int COORD_BITS  = 12,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input words
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero pad to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_tdata,
    // command
    input  logic                                     s_tuser,
    // result words
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // main_x, main_y, main_weight, pair_x, pair_y, pair_weight from bit 0 up, zero pad
    output logic [((4*COORD_BITS+2*WEIGHT_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]                               m_tuser,
    output logic                                     m_tlast,
    // clip register writes
    input  logic                                     cfg_wr_en,
    input  logic [1:0]                               cfg_addr,
    input  logic [alstep_pkg::CLIP_BITS-1:0]         cfg_wdata
);

    localparam int CB = COORD_BITS;
    localparam int WB = WEIGHT_BITS;
    localparam int M_W = ((4*CB + 2*WB + 7) / 8) * 8;
    // internal coordinate width: wide enough for inputs and clip values
    localparam int VB = (CB > alstep_pkg::CLIP_BITS) ? CB : alstep_pkg::CLIP_BITS;
    localparam int EW = $bits(alstep_pkg::entry_ctl_t) + 4*VB;
    localparam int QUEUE_DEPTH = 2;

    alstep_pkg::clip_t      clip_reg;
    alstep_pkg::entry_ctl_t f_ctl, q_ctl;
    alstep_pkg::status_t    out_status;

    logic signed [VB-1:0] f_x1, f_y1, f_x2, f_y2;
    logic signed [VB-1:0] q_x1, q_y1, q_x2, q_y2;
    logic [EW-1:0]        q_wdata, q_rdata;
    logic                 q_full, q_push, q_pop, q_valid;

    logic [CB-1:0] mx, my, px, py;
    logic [WB-1:0] mw, pw;

    // clip registers; written by index on any cycle with cfg_wr_en, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg.left   <= alstep_pkg::CLIP_LEFT_RST;
            clip_reg.right  <= alstep_pkg::CLIP_RIGHT_RST;
            clip_reg.top    <= alstep_pkg::CLIP_TOP_RST;
            clip_reg.bottom <= alstep_pkg::CLIP_BOTTOM_RST;
        end else if (cfg_wr_en) begin
            unique case (alstep_pkg::cfg_reg_t'(cfg_addr))
                alstep_pkg::REG_CLIP_LEFT:   clip_reg.left   <= cfg_wdata;
                alstep_pkg::REG_CLIP_RIGHT:  clip_reg.right  <= cfg_wdata;
                alstep_pkg::REG_CLIP_TOP:    clip_reg.top    <= cfg_wdata;
                alstep_pkg::REG_CLIP_BOTTOM: clip_reg.bottom <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: classify and clamp in the accept cycle, result goes straight to the queue
    alstep_front #(
        .COORD_BITS (CB),
        .VB         (VB)
    ) u_front (
        .cmd     (s_tuser),
        .start_x (s_tdata[CB-1:0]),
        .start_y (s_tdata[2*CB-1:CB]),
        .end_x   (s_tdata[3*CB-1:2*CB]),
        .end_y   (s_tdata[4*CB-1:3*CB]),
        .clip    (clip_reg),
        .ctl     (f_ctl),
        .x1      (f_x1),
        .y1      (f_y1),
        .x2      (f_x2),
        .y2      (f_y2)
    );

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_wdata  = {f_ctl, f_x1, f_y1, f_x2, f_y2};

    alstep_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    assign {q_ctl, q_x1, q_y1, q_x2, q_y2} = q_rdata;

    // back: setup, divide, step; owns the output register
    alstep_back #(
        .COORD_BITS  (CB),
        .WEIGHT_BITS (WB),
        .VB          (VB)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ctl           (q_ctl),
        .q_x1            (q_x1),
        .q_y1            (q_y1),
        .q_x2            (q_x2),
        .q_y2            (q_y2),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_main_x      (mx),
        .out_main_y      (my),
        .out_main_weight (mw),
        .out_pair_x      (px),
        .out_pair_y      (py),
        .out_pair_weight (pw),
        .out_last        (m_tlast)
    );

    assign m_tdata = M_W'({pw, py, px, mw, my, mx});
    assign m_tuser = out_status;

`ifndef SYNTHESIS
    a_span_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == alstep_pkg::STAT_SPAN) |-> m_tlast)
        else $error("solid span word without last");
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == alstep_pkg::STAT_REJECT ||
                      m_tuser == alstep_pkg::STAT_IDLE_STEP)) |-> (m_tdata == '0 && !m_tlast))
        else $error("reject or idle-step word carries data");
`endif

endmodule

// File: verif/antialiased_line_stepper_core_tb.sv
// Self-checking testbench for the antialiased line stepper core.
`timescale 1ns / 1ps

module antialiased_line_stepper_core_tb;

    localparam int COORD_BITS  = 12;
    localparam int WEIGHT_BITS = 8;
    localparam int S_BITS      = ((4*COORD_BITS+7)/8)*8;
    localparam int M_BITS      = ((4*COORD_BITS+2*WEIGHT_BITS+7)/8)*8;

    localparam logic [7:0] FULL_WEIGHT = 8'hFF;
    localparam int CYCLE_LIMIT = 300000;  // watchdog bound on the whole run, in cycles
    localparam int LONG_HOLD   = 400;     // receiver back-pressure stretch, in cycles
    localparam int DRAIN       = 40;      // quiet cycles after the last result
    localparam int MAX_SHOWN   = 10;

    // One input word, fields at block widths.
    typedef struct packed {
        alstep_pkg::cmd_t cmd;
        logic [11:0]      sx;
        logic [11:0]      sy;
        logic [11:0]      ex;
        logic [11:0]      ey;
    } line_cmd_t;

    // One result word.
    typedef struct packed {
        alstep_pkg::status_t status;
        logic [11:0]         mx;
        logic [11:0]         my;
        logic [7:0]          mw;
        logic [11:0]         px;
        logic [11:0]         py;
        logic [7:0]          pw;
        logic                last;
    } pixel_t;

    // Directed stimulus row: typed result only where it is obvious.
    typedef struct packed {
        line_cmd_t w;
        bit        typed;
        pixel_t    res;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_addr  = '0;
    logic [alstep_pkg::CLIP_BITS-1:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    antialiased_line_stepper_core #(
        .COORD_BITS  (COORD_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Line tracker: our own copy of the clip window and stepping state.
    // ------------------------------------------------------------------
    logic [11:0] clip_l, clip_r, clip_t, clip_b;
    logic        trk_active, trk_y_major, trk_x_neg;
    logic [12:0] trk_steps;
    logic [31:0] trk_acc;
    logic [15:0] trk_err_step;
    logic [11:0] trk_x, trk_y, trk_nb;

    pixel_t pixel_q[$];      // expected result words, oldest first
    dir_row_t dir_rows[$];

    int  words_sent   = 0;
    int  fault_count  = 0;
    int  status_seen[4];
    int  lines_done   = 0;
    int  clip_sets    = 0;
    int  cycle_count  = 0;
    bit  tx_calm      = 1'b0;  // sender runs without gaps while set
    bit  rx_calm      = 1'b0;  // receiver runs without stalls while set
    bit  long_hold_req = 1'b0;

    function automatic void reset_tracker();
        clip_l = alstep_pkg::CLIP_LEFT_RST;
        clip_r = alstep_pkg::CLIP_RIGHT_RST;
        clip_t = alstep_pkg::CLIP_TOP_RST;
        clip_b = alstep_pkg::CLIP_BOTTOM_RST;
        trk_active   = 1'b0;
        trk_y_major  = 1'b0;
        trk_x_neg    = 1'b0;
        trk_steps    = '0;
        trk_acc      = '0;
        trk_err_step = '0;
        trk_x        = '0;
        trk_y        = '0;
        trk_nb       = '0;
    endfunction

    // Advance the tracker by one accepted word and return the pixel word it yields.
    function automatic pixel_t trace_pixel(line_cmd_t w);
        pixel_t      r;
        int          x1, y1, x2, y2, t, dx, dy, maj, mnr;
        logic [31:0] acc_prev;
        logic [7:0]  wgt;
        logic [11:0] dir;
        logic        rolled;
        r = '0;
        if (w.cmd == alstep_pkg::CMD_START) begin
            x1 = $signed(w.sx);
            y1 = $signed(w.sy);
            x2 = $signed(w.ex);
            y2 = $signed(w.ey);
            trk_active = 1'b0;  // any line in flight is dropped
            if (x1 == x2) begin
                r.status = alstep_pkg::STAT_REJECT;
                return r;
            end
            // order by x, keeping each endpoint whole
            if (x2 < x1) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            if (y1 < int'($signed(clip_t)) || y1 >= int'($signed(clip_b))) begin
                r.status = alstep_pkg::STAT_REJECT;
                return r;
            end
            if (x1 < int'($signed(clip_l))) x1 = $signed(clip_l);
            if (x2 >= int'($signed(clip_r))) x2 = $signed(clip_r);
            if (x1 == x2 || y1 == y2) begin
                r.status = alstep_pkg::STAT_SPAN;
                r.mx = 12'(x1);
                r.my = 12'(y1);
                r.mw = FULL_WEIGHT;
                r.px = 12'(x2);
                r.py = 12'(y2);
                r.pw = FULL_WEIGHT;
                r.last = 1'b1;
                return r;
            end
            if (y1 > y2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            trk_x_neg = dx < 0;
            if (dx < 0) dx = -dx;
            trk_y_major = dy > dx;
            maj = trk_y_major ? dy : dx;
            mnr = trk_y_major ? dx : dy;
            // a diagonal wraps to zero
            trk_err_step = 16'((mnr << alstep_pkg::FRAC_BITS) / maj);
            trk_acc   = '0;
            trk_steps = 13'(maj - 1);
            trk_x     = 12'(x1);
            trk_y     = 12'(y1);
            if (trk_y_major)
                trk_nb = trk_x + (trk_x_neg ? 12'hFFF : 12'd1);
            else
                trk_nb = trk_y + 12'd1;
            trk_active = trk_steps != 0;
            r.status = alstep_pkg::STAT_PAIR;
            r.mx = trk_x;
            r.my = trk_y;
            r.mw = FULL_WEIGHT;
            r.px = trk_x;
            r.py = trk_y;
            r.pw = '0;
            r.last = !trk_active;
            return r;
        end
        if (!trk_active) begin
            r.status = alstep_pkg::STAT_IDLE_STEP;
            return r;
        end
        dir      = trk_x_neg ? 12'hFFF : 12'd1;
        acc_prev = trk_acc;
        trk_acc  = trk_acc + {trk_err_step, 16'h0000};
        wgt      = trk_acc[31:24];
        rolled   = trk_acc <= acc_prev;  // adding zero counts as a rollover
        if (trk_y_major) begin
            if (rolled) begin
                trk_x  = trk_nb;
                trk_nb = trk_nb + dir;
            end
            trk_y = trk_y + 12'd1;
        end else begin
            if (rolled) begin
                trk_y  = trk_nb;
                trk_nb = trk_nb + 12'd1;
            end
            trk_x = trk_x + dir;
        end
        trk_steps  = trk_steps - 13'd1;
        trk_active = trk_steps != 0;
        r.status = alstep_pkg::STAT_PAIR;
        r.mx = trk_x;
        r.my = trk_y;
        r.mw = FULL_WEIGHT - wgt;
        r.pw = wgt;
        r.last = !trk_active;
        r.px = trk_y_major ? trk_nb : trk_x;
        r.py = trk_y_major ? trk_y : trk_nb;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic line_cmd_t cmd_word(alstep_pkg::cmd_t c, int sx, int sy, int ex,
                                           int ey);
        line_cmd_t w;
        w.cmd = c;
        w.sx  = 12'(sx);
        w.sy  = 12'(sy);
        w.ex  = 12'(ex);
        w.ey  = 12'(ey);
        return w;
    endfunction

    function automatic pixel_t pix(alstep_pkg::status_t s, int mx, int my, int mw, int px,
                                   int py, int pw, bit last);
        pixel_t r;
        r.status = s;
        r.mx = 12'(mx);
        r.my = 12'(my);
        r.mw = 8'(mw);
        r.px = 12'(px);
        r.py = 12'(py);
        r.pw = 8'(pw);
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t row_typed(line_cmd_t w, pixel_t r);
        dir_row_t d;
        d.w = w;
        d.typed = 1'b1;
        d.res = r;
        return d;
    endfunction

    function automatic dir_row_t row_pred(line_cmd_t w);
        dir_row_t d;
        d.w = w;
        d.typed = 1'b0;
        d.res = '0;
        return d;
    endfunction

    function automatic int rand_in(int lo, int hi);
        int t;
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Offer one word, wait for the handshake, then log what it should produce.
    task automatic send_word(input line_cmd_t w, input bit typed, input pixel_t typed_res);
        int     gap;
        pixel_t r;
        if ($urandom_range(31, 0) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(16, 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {w.ey, w.ex, w.sy, w.sx};
        do @(posedge aclk); while (!s_tready);
        r = trace_pixel(w);
        pixel_q.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    // Reprogram the clip window once every outstanding result has drained.
    task automatic set_clips(input int l, input int r, input int t, input int b);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= alstep_pkg::REG_CLIP_LEFT;
        cfg_wdata <= 12'(l);
        @(posedge aclk);
        clip_l = 12'(l);
        cfg_addr  <= alstep_pkg::REG_CLIP_RIGHT;
        cfg_wdata <= 12'(r);
        @(posedge aclk);
        clip_r = 12'(r);
        cfg_addr  <= alstep_pkg::REG_CLIP_TOP;
        cfg_wdata <= 12'(t);
        @(posedge aclk);
        clip_t = 12'(t);
        cfg_addr  <= alstep_pkg::REG_CLIP_BOTTOM;
        cfg_wdata <= 12'(b);
        @(posedge aclk);
        clip_b = 12'(b);
        cfg_wr_en <= 1'b0;
        clip_sets++;
    endtask

    // Random traffic: mostly whole lines (start then steps until the last pair),
    // with noise words, broken lines and abandoned lines mixed in.
    task automatic run_lines(input int n, input int hold_at);
        int base, pick, x1, y1, x2, y2, t, cap;
        bit long_line;
        base = words_sent;
        while (words_sent - base < n) begin
            if (words_sent - base >= hold_at && hold_at >= 0 && !long_hold_req) begin
                long_hold_req = 1'b1;
                hold_at = -1;
            end
            pick = $urandom_range(99, 0);
            if (pick < 15) begin
                // noise: any command, every field full range
                send_word(cmd_word(alstep_pkg::cmd_t'($urandom_range(1, 0)), $urandom,
                                   $urandom, $urandom, $urandom), 1'b0, '0);
            end else if (pick < 22) begin
                // broken: random start followed by a few steps
                send_word(cmd_word(alstep_pkg::CMD_START, $urandom, $urandom, $urandom,
                                   $urandom), 1'b0, '0);
                cap = rand_in(0, 3);
                while (cap > 0 && words_sent - base < n) begin
                    send_word(cmd_word(alstep_pkg::CMD_STEP, $urandom, $urandom, $urandom,
                                       $urandom), 1'b0, '0);
                    cap--;
                end
            end else begin
                long_line = $urandom_range(19, 0) == 0;
                x1 = rand_in($signed(clip_l), $signed(clip_r));
                y1 = rand_in($signed(clip_t), int'($signed(clip_b)) - 1);
                if (long_line) begin
                    x2 = rand_in(-2048, 2047);
                    y2 = rand_in($signed(clip_t), int'($signed(clip_b)) - 1);
                end else begin
                    x2 = clamp_coord(x1 + rand_in(-24, 24));
                    y2 = clamp_coord(y1 + rand_in(-24, 24));
                end
                if ($urandom_range(19, 0) == 0) y2 = y1;
                if ($urandom_range(1, 0) == 1) begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                send_word(cmd_word(alstep_pkg::CMD_START, x1, y1, x2, y2), 1'b0, '0);
                if (long_line)
                    cap = rand_in(1, 40);
                else if ($urandom_range(11, 0) == 0)
                    cap = rand_in(0, 3);   // abandoned by the next start
                else
                    cap = 5000;
                while (trk_active && cap > 0 && words_sent - base < n) begin
                    send_word(cmd_word(alstep_pkg::CMD_STEP, $urandom, $urandom, $urandom,
                                       $urandom), 1'b0, '0);
                    cap--;
                end
                if ($urandom_range(9, 0) == 0 && words_sent - base < n)
                    send_word(cmd_word(alstep_pkg::CMD_STEP, $urandom, $urandom, $urandom,
                                       $urandom), 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(39, 0) == 0) rx_calm = !rx_calm;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;  // let the queue fill and back up the input
            end else begin
                stall = rx_calm ? 0 : $urandom_range(16, 0);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic show_fault(input string what, input pixel_t want, input pixel_t got);
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
            $display("%0t %s: want st=%0d m=(%0d,%0d,%0d) p=(%0d,%0d,%0d) l=%0b",
                     $realtime, what,
                     want.status, $signed(want.mx), $signed(want.my), want.mw,
                     $signed(want.px), $signed(want.py), want.pw, want.last);
            $display("    got st=%0d m=(%0d,%0d,%0d) p=(%0d,%0d,%0d) l=%0b",
                     got.status, $signed(got.mx), $signed(got.my), got.mw,
                     $signed(got.px), $signed(got.py), got.pw, got.last);
        end
    endtask

    // Checker: every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        pixel_t got, want;
        bit     bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = alstep_pkg::status_t'(m_tuser);
            got.mx   = m_tdata[11:0];
            got.my   = m_tdata[23:12];
            got.mw   = m_tdata[31:24];
            got.px   = m_tdata[43:32];
            got.py   = m_tdata[55:44];
            got.pw   = m_tdata[63:56];
            got.last = m_tlast;
            status_seen[got.status]++;
            if (got.status == alstep_pkg::STAT_PAIR && got.last) lines_done++;
            if (pixel_q.size() == 0) begin
                show_fault("unexpected word", '0, got);
            end else begin
                want = pixel_q.pop_front();
                bad = (got.status !== want.status) || (got.mx !== want.mx) ||
                      (got.my !== want.my) || (got.mw !== want.mw) ||
                      (got.px !== want.px) || (got.py !== want.py) ||
                      (got.pw !== want.pw) || (got.last !== want.last);
                if (bad) show_fault("mismatch", want, got);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycle_count, pixel_q.size());
        $display("antialiased_line_stepper_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_tracker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under the reset clip window (0..2047 both ways).
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_STEP, 0, 0, 0, 0),
                                     pix(alstep_pkg::STAT_IDLE_STEP, 0, 0, 0, 0, 0, 0, 0)));
        // equal x
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 5, 5, 5, 100),
                                     pix(alstep_pkg::STAT_REJECT, 0, 0, 0, 0, 0, 0, 0)));
        // left y above the clip rows
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 10, -1, 20, 30),
                                     pix(alstep_pkg::STAT_REJECT, 0, 0, 0, 0, 0, 0, 0)));
        // left y on the bottom limit
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 0, 2047, 1, 0),
                                     pix(alstep_pkg::STAT_REJECT, 0, 0, 0, 0, 0, 0, 0)));
        // endpoints swapped by x: the left y is the one tested
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 20, 30, 10, -5),
                                     pix(alstep_pkg::STAT_REJECT, 0, 0, 0, 0, 0, 0, 0)));
        // horizontal span
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 10, 50, 40, 50),
                                     pix(alstep_pkg::STAT_SPAN, 10, 50, 255, 40, 50, 255, 1)));
        // full-range span clamped on both ends
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, -2048, 3, 2047, 3),
                                     pix(alstep_pkg::STAT_SPAN, 0, 3, 255, 2047, 3, 255, 1)));
        // one-step diagonal: start pixel is also the last
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_START, 0, 0, 1, 1),
                                     pix(alstep_pkg::STAT_PAIR, 0, 0, 255, 0, 0, 0, 1)));
        dir_rows.push_back(row_typed(cmd_word(alstep_pkg::CMD_STEP, -1, -1, -1, -1),
                                     pix(alstep_pkg::STAT_IDLE_STEP, 0, 0, 0, 0, 0, 0, 0)));
        // longer diagonal: zero step, minor moves every time; one step past the end
        dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_START, 100, 100, 104, 104)));
        repeat (4) dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_STEP, 0, 0, 0, 0)));
        // shallow x-major, abandoned after two steps by a new start
        dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_START, 0, 10, 10, 13)));
        repeat (2) dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_STEP, 0, 0, 0, 0)));
        dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_START, 50, 60, 20, 40)));
        repeat (2)
            dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_STEP, -1, -1, -1, -1)));
        // y-major going left
        dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_START, 30, 0, 25, 20)));
        repeat (3) dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_STEP, 0, 0, 0, 0)));
        // coordinate extremes, clamped at both ends, y order reversed
        dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_START, 2047, 0, -2048, 2046)));
        repeat (2)
            dir_rows.push_back(row_pred(cmd_word(alstep_pkg::CMD_STEP, -1, -1, -1, -1)));

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        // Random phases over several clip windows.
        set_clips(0, 2047, 0, 2047);
        run_lines(180, -1);
        set_clips(-2048, 2047, -2048, 2047);
        run_lines(180, 60);
        set_clips(100, 400, 50, 300);
        run_lines(160, -1);
        // left beyond right: clamped ends cross
        set_clips(500, -500, -2048, 2047);
        run_lines(160, -1);
        // every start row rejected
        set_clips(2047, -2048, -2048, -2048);
        run_lines(40, -1);
        set_clips(rand_in(-2048, 1000), rand_in(-1000, 2047),
                  rand_in(-2048, 1000), rand_in(-1000, 2047));
        run_lines(200, -1);

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("sent %0d words over %0d clip windows in %0d cycles; %0d lines run to the end",
                 words_sent, clip_sets + 1, cycle_count, lines_done);
        $display("results: %0d pairs, %0d rejects, %0d spans, %0d idle steps; %0d faults",
                 status_seen[alstep_pkg::STAT_PAIR], status_seen[alstep_pkg::STAT_REJECT],
                 status_seen[alstep_pkg::STAT_SPAN], status_seen[alstep_pkg::STAT_IDLE_STEP],
                 fault_count);
        if (fault_count == 0 && pixel_q.size() == 0) begin
            $display("antialiased_line_stepper_core verification clean");
        end else begin
            $display("antialiased_line_stepper_core verification failed");
        end
        $finish;
    end

endmodule
